FILE: design/gcsm_pkg.sv
// gcsm_pkg: shared widths, constants, types and helpers for the grouped
// circular sliding maximum block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gcsm_pkg;

    // buffer and field geometry
    localparam int BLOCK_MAX = 64;
    localparam int SAMPLE_W  = 32;
    localparam int CFG_W     = 7;
    localparam int ADDR_W    = $clog2(BLOCK_MAX);
    localparam int CNT_W     = $clog2(BLOCK_MAX + 1);
    localparam int PROD_W    = 2 * CFG_W;

    // queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_WINDOW_LEN = 1'b0,
        CFG_WIN_PER_GRP = 1'b1
    } t_cfg_idx;

    // one queued sample with its classification
    typedef struct packed {
        t_sample             sample;
        logic [ADDR_W-1:0]   pos;
        logic                release_grp;
        logic [CNT_W-1:0]    win;
    } t_q_entry;

    // queue status seen by the front
    typedef struct packed {
        logic push;
        logic full;
    } t_q_ctrl;

    // window length with zero taken as one and saturated at the buffer size
    function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] r);
        logic [CNT_W-1:0] res;
        if (r == '0) begin
            res = CNT_W'(1);
        end else if (CNT_W'(r) > CNT_W'(BLOCK_MAX)) begin
            res = CNT_W'(BLOCK_MAX);
        end else begin
            res = CNT_W'(r);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/gcsm_if.sv
// gcsm_in_if / gcsm_out_if: valid-ready channels for samples and results.
// Depends on gcsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gcsm_in_if;
    logic               valid;
    logic               ready;
    gcsm_pkg::t_sample  sample;
    logic               end_of_series;

    modport source (output valid, output sample, output end_of_series, input ready);
    modport sink   (input valid, input sample, input end_of_series, output ready);
endinterface

interface gcsm_out_if;
    logic               valid;
    logic               ready;
    gcsm_pkg::t_sample  block_max;
    logic               last_of_run;

    modport source (output valid, output block_max, output last_of_run, input ready);
    modport sink   (input valid, input block_max, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: design/gcsm_front.sv
// gcsm_front: configuration registers, sample acceptance and group
// classification (fill position, release decision, window length).
// Depends on gcsm_pkg and gcsm_if.
`timescale 1ns / 1ps
`default_nettype none

module gcsm_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire gcsm_pkg::t_cfg_idx           i_cfg_idx,
    input  wire logic [gcsm_pkg::CFG_W-1:0]   i_cfg_data,
    gcsm_in_if.sink                           i_in,
    input  wire logic                         i_q_full,
    output gcsm_pkg::t_q_ctrl                 o_q_ctrl,
    output gcsm_pkg::t_q_entry                o_q_entry
);

    logic [gcsm_pkg::CFG_W-1:0]  r_window_len;
    logic [gcsm_pkg::CFG_W-1:0]  r_win_per_grp;
    logic [gcsm_pkg::CNT_W-1:0]  r_fill;
    logic [gcsm_pkg::CNT_W-1:0]  n_fill;

    logic [gcsm_pkg::CNT_W-1:0]  w_eff;
    logic [gcsm_pkg::CFG_W-1:0]  k_eff;
    logic [gcsm_pkg::PROD_W-1:0] grp_prod;
    logic [gcsm_pkg::CNT_W-1:0]  grp_len;
    logic [gcsm_pkg::CNT_W-1:0]  fill_inc;
    logic                        rel;
    logic                        accept;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len  <= gcsm_pkg::CFG_W'(2);
            r_win_per_grp <= gcsm_pkg::CFG_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gcsm_pkg::CFG_WINDOW_LEN:  r_window_len  <= i_cfg_data;
                gcsm_pkg::CFG_WIN_PER_GRP: r_win_per_grp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective window and group length
    always_comb begin
        w_eff    = gcsm_pkg::eff_window(r_window_len);
        k_eff    = (r_win_per_grp == '0) ? gcsm_pkg::CFG_W'(1) : r_win_per_grp;
        grp_prod = gcsm_pkg::PROD_W'(w_eff) * gcsm_pkg::PROD_W'(k_eff);
        grp_len  = (grp_prod > gcsm_pkg::PROD_W'(gcsm_pkg::BLOCK_MAX))
                   ? gcsm_pkg::CNT_W'(gcsm_pkg::BLOCK_MAX) : grp_prod[gcsm_pkg::CNT_W-1:0];
    end

    // classify the incoming sample
    always_comb begin
        accept   = i_in.valid && !i_q_full;
        fill_inc = r_fill + gcsm_pkg::CNT_W'(1);
        rel      = i_in.end_of_series || (fill_inc >= grp_len)
                   || (fill_inc >= gcsm_pkg::CNT_W'(gcsm_pkg::BLOCK_MAX));
        n_fill   = r_fill;
        if (accept) begin
            n_fill = rel ? '0 : fill_inc;
        end
        o_q_entry.sample      = i_in.sample;
        o_q_entry.pos         = r_fill[gcsm_pkg::ADDR_W-1:0];
        o_q_entry.release_grp = rel;
        o_q_entry.win         = (w_eff > fill_inc) ? fill_inc : w_eff;
        o_q_ctrl.push         = accept;
        o_q_ctrl.full         = i_q_full;
    end

    assign i_in.ready = !i_q_full;

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

`ifndef NO_ASSERTIONS
    // a group never stays open at the buffer size
    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < gcsm_pkg::CNT_W'(gcsm_pkg::BLOCK_MAX))
        else $error("fill count reached buffer size without release");
`endif

endmodule

`default_nettype wire

FILE: design/gcsm_queue.sv
// gcsm_queue: short first-in first-out queue of classified samples between
// the front and the back. Depends on gcsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcsm_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gcsm_pkg::t_q_ctrl    i_ctrl,
    input  wire gcsm_pkg::t_q_entry   i_entry,
    output logic                      o_full,
    output logic                      o_valid,
    input  wire logic                 i_pop,
    output gcsm_pkg::t_q_entry        o_entry
);

    gcsm_pkg::t_q_entry           r_slot [gcsm_pkg::QUEUE_DEPTH];
    logic [gcsm_pkg::QPTR_W-1:0]  r_wp;
    logic [gcsm_pkg::QPTR_W-1:0]  r_rp;
    logic [gcsm_pkg::QCNT_W-1:0]  r_cnt;
    logic                         do_push;
    logic                         do_pop;

    always_comb begin
        o_full  = (r_cnt == gcsm_pkg::QCNT_W'(gcsm_pkg::QUEUE_DEPTH));
        o_valid = (r_cnt != '0);
        do_push = i_ctrl.push && !i_ctrl.full;
        do_pop  = i_pop && o_valid;
        o_entry = r_slot[r_rp];
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_entry;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + gcsm_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + gcsm_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + gcsm_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - gcsm_pkg::QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/gcsm_back.sv
// gcsm_back: group buffer, circular window scan with a running maximum and
// the result register. Depends on gcsm_pkg and gcsm_if.
`timescale 1ns / 1ps
`default_nettype none

module gcsm_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire gcsm_pkg::t_q_entry   i_q_entry,
    output logic                      o_q_pop,
    gcsm_out_if.source                o_out
);

    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_SCAN = 2'b10
    } t_back_state;

    t_back_state                  r_state;
    gcsm_pkg::t_sample            r_mem [gcsm_pkg::BLOCK_MAX];

    logic [gcsm_pkg::CNT_W-1:0]   r_f;
    logic [gcsm_pkg::CNT_W-1:0]   r_w;
    logic [gcsm_pkg::ADDR_W-1:0]  r_i;
    logic [gcsm_pkg::ADDR_W-1:0]  r_j;
    logic [gcsm_pkg::ADDR_W-1:0]  r_addr;

    gcsm_pkg::t_sample            r_rd_data;
    logic                         r_rd_vld;
    logic                         r_rd_first;
    logic                         r_rd_last;
    logic                         r_rd_final;

    gcsm_pkg::t_sample            r_acc;
    gcsm_pkg::t_sample            r_out_max;
    logic                         r_out_vld;
    logic                         r_out_last;

    logic                         stall;
    logic                         issue;
    logic                         is_first;
    logic                         is_last;
    logic                         is_final;
    logic [gcsm_pkg::CNT_W-1:0]   addr_inc;
    gcsm_pkg::t_sample            acc_val;
    logic                         load_out;

    // scan control decode
    always_comb begin
        stall    = r_out_vld && !o_out.ready;
        issue    = (r_state == ST_SCAN) && !stall;
        is_first = (r_j == '0);
        is_last  = (gcsm_pkg::CNT_W'(r_j) + gcsm_pkg::CNT_W'(1)) == r_w;
        is_final = is_last && ((gcsm_pkg::CNT_W'(r_i) + gcsm_pkg::CNT_W'(1)) == r_f);
        addr_inc = gcsm_pkg::CNT_W'(r_addr) + gcsm_pkg::CNT_W'(1);
        o_q_pop  = (r_state == ST_FILL) && i_q_valid;
        if (r_rd_first || (r_rd_data > r_acc)) begin
            acc_val = r_rd_data;
        end else begin
            acc_val = r_acc;
        end
        load_out = r_rd_vld && r_rd_last && !stall;
    end

    // group buffer: written on queue pop, read once per scan step
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mem[i_q_entry.pos] <= i_q_entry.sample;
        end
        if (!stall) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // state machine and scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_f     <= '0;
            r_w     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_addr  <= '0;
        end else begin
            unique case (r_state)
                ST_FILL: begin
                    if (o_q_pop && i_q_entry.release_grp) begin
                        r_f     <= gcsm_pkg::CNT_W'(i_q_entry.pos) + gcsm_pkg::CNT_W'(1);
                        r_w     <= i_q_entry.win;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_addr  <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        if (is_final) begin
                            r_state <= ST_FILL;
                        end else if (is_last) begin
                            r_j    <= '0;
                            r_i    <= r_i + gcsm_pkg::ADDR_W'(1);
                            r_addr <= r_i + gcsm_pkg::ADDR_W'(1);
                        end else begin
                            r_j    <= r_j + gcsm_pkg::ADDR_W'(1);
                            r_addr <= (addr_inc == r_f) ? '0
                                      : addr_inc[gcsm_pkg::ADDR_W-1:0];
                        end
                    end
                end
                default: r_state <= ST_FILL;
            endcase
        end
    end

    // read stage tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (!stall) begin
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_rd_first <= is_first;
            r_rd_last  <= is_last;
            r_rd_final <= is_final;
        end
    end

    // running maximum and result register
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && !stall) begin
            r_acc <= acc_val;
        end
        if (load_out) begin
            r_out_max  <= acc_val;
            r_out_last <= r_rd_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.block_max   = r_out_max;
    assign o_out.last_of_run = r_out_last;

`ifndef NO_ASSERTIONS
    // scan geometry is sane for the whole scan
    a_scan_geom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_w != '0) && (r_w <= r_f))
        else $error("window length out of range during scan");
    // read address stays inside the group
    a_addr_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (gcsm_pkg::CNT_W'(r_addr) < r_f))
        else $error("scan address beyond group length");
    // the queue is not drained while a group is being scanned
    a_no_pop_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !o_q_pop)
        else $error("queue popped during scan");
    // the final result of a group ends the scan
    a_final_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && is_final) |=> (r_state == ST_FILL))
        else $error("scan did not end after final read");
`endif

endmodule

`default_nettype wire

FILE: design/grouped_circular_sliding_max.sv
// grouped_circular_sliding_max: top level joining front, queue and back.
// Depends on gcsm_pkg, gcsm_if, gcsm_front, gcsm_queue and gcsm_back.
`timescale 1ns / 1ps
`default_nettype none

// Samples are taken one per cycle, while the queue is not full, into a
// two-entry queue and written into a 64-entry group buffer; a group is
// released when it reaches min(k*r, 64) samples or on end_of_series. On
// release the back end scans the buffer with one memory read per cycle,
// unless a result waits in the output register, and a running maximum, so
// a group of f samples yields its f results, during which no further
// sample leaves the queue. Throughput is set by the single read port of
// the group buffer. Results stall cleanly under back-pressure; while a
// result waits in the output register the whole scan holds.
module grouped_circular_sliding_max (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire gcsm_pkg::t_cfg_idx           i_cfg_idx,
    input  wire logic [gcsm_pkg::CFG_W-1:0]   i_cfg_data,
    gcsm_in_if.sink                           i_in,
    gcsm_out_if.source                        o_out
);

    gcsm_pkg::t_q_ctrl   q_ctrl;
    gcsm_pkg::t_q_entry  q_in_entry;
    gcsm_pkg::t_q_entry  q_out_entry;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;

    // acceptance and classification
    gcsm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_q_ctrl   (q_ctrl),
        .o_q_entry  (q_in_entry)
    );

    // decoupling queue
    gcsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_entry (q_in_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_out_entry)
    );

    // buffer and window scan
    gcsm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_out_entry),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

FILE: tb/sliding_max_checker.sv
// sliding_max_checker: watches the configuration port and both channels,
// predicts each group's sliding maxima and compares them with the results.
// Depends on gcsm_pkg and gcsm_if.
`timescale 1ns / 1ps

module sliding_max_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire gcsm_pkg::t_cfg_idx           i_cfg_idx,
    input  wire logic [gcsm_pkg::CFG_W-1:0]   i_cfg_data,
    gcsm_in_if                                i_in_mon,
    gcsm_out_if                               i_out_mon,
    output int                                o_failures,
    output int                                o_pending
);

    // one predicted result
    typedef struct packed {
        gcsm_pkg::t_sample block_max;
        logic              last_of_run;
    } t_max_result;

    gcsm_pkg::t_sample          group_mem [gcsm_pkg::BLOCK_MAX];
    int unsigned                fill;
    logic [gcsm_pkg::CFG_W-1:0] win_reg;
    logic [gcsm_pkg::CFG_W-1:0] grp_reg;
    t_max_result                max_due_q [$];
    int                         failures = 0;

    // window length: zero counts as one, capped at the buffer size
    function automatic int unsigned window_eff();
        int unsigned r;
        r = win_reg;
        if (r < 1) r = 1;
        if (r > gcsm_pkg::BLOCK_MAX) r = gcsm_pkg::BLOCK_MAX;
        return r;
    endfunction

    // group length: k times r, zero k counts as one, capped at the buffer size
    function automatic int unsigned group_eff();
        int unsigned k;
        int unsigned g;
        k = grp_reg;
        if (k < 1) k = 1;
        g = k * window_eff();
        if (g > gcsm_pkg::BLOCK_MAX) g = gcsm_pkg::BLOCK_MAX;
        return g;
    endfunction

    // buffer one sample and, on release, queue the circular window maxima
    function automatic void take_sample(gcsm_pkg::t_sample s, logic eos);
        int unsigned       f;
        int unsigned       w;
        int unsigned       idx;
        gcsm_pkg::t_sample m;
        if (fill >= gcsm_pkg::BLOCK_MAX) fill = 0;
        group_mem[fill] = s;
        fill++;
        if (!(eos || fill >= group_eff() || fill >= gcsm_pkg::BLOCK_MAX)) return;
        f = fill;
        w = window_eff();
        if (w > f) w = f;
        for (int unsigned i = 0; i < f; i++) begin
            m = group_mem[i];
            for (int unsigned j = 1; j < w; j++) begin
                idx = i + j;
                if (idx >= f) idx -= f;
                if (group_mem[idx] > m) m = group_mem[idx];
            end
            max_due_q.push_back('{block_max: m, last_of_run: logic'(i + 1 == f)});
        end
        fill = 0;
    endfunction

    // register writes, sample transactions and result checks
    always @(posedge i_clk) begin
        t_max_result want;
        if (!i_rst_n) begin
            fill    = 0;
            win_reg = 7'd2;
            grp_reg = 7'd2;
            max_due_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gcsm_pkg::CFG_WINDOW_LEN:  win_reg = i_cfg_data;
                    gcsm_pkg::CFG_WIN_PER_GRP: grp_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                take_sample(i_in_mon.sample, i_in_mon.end_of_series);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (max_due_q.size() == 0) begin
                    $error("unexpected result: block_max %0d last_of_run %0b",
                           i_out_mon.block_max, i_out_mon.last_of_run);
                    failures++;
                end else begin
                    want = max_due_q.pop_front();
                    if (i_out_mon.block_max !== want.block_max) begin
                        $error("block_max: expected %0d, got %0d",
                               want.block_max, i_out_mon.block_max);
                        failures++;
                    end
                    if (i_out_mon.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, i_out_mon.last_of_run);
                        failures++;
                    end
                end
            end
        end
        o_failures <= failures;
        o_pending  <= max_due_q.size();
    end

endmodule

FILE: tb/grouped_circular_sliding_max_test.sv
// grouped_circular_sliding_max_test: clock, reset, register writes and sample
// stimulus with random gaps and back-pressure; verdict from sliding_max_checker.
// Depends on gcsm_pkg, gcsm_if, grouped_circular_sliding_max and the checker.
`timescale 1ns / 1ps

module grouped_circular_sliding_max_test;

    localparam int          RANDOM_ITEMS   = 300;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] SAMPLE_MIN     = 32'h8000_0000;
    localparam logic [31:0] SAMPLE_MAX     = 32'h7fff_ffff;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       cfg_we;
    gcsm_pkg::t_cfg_idx         cfg_idx;
    logic [gcsm_pkg::CFG_W-1:0] cfg_data;
    int                         failures;
    int                         pending;
    int                         quiet_cycles;
    bit                         calm;

    gcsm_in_if  in_ch ();
    gcsm_out_if out_ch ();

    grouped_circular_sliding_max i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    sliding_max_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .o_failures (failures),
        .o_pending  (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned gap_len();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sample values: extremes, small values for ties, and full range
    function automatic gcsm_pkg::t_sample draw_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2, 3:    return gcsm_pkg::t_sample'(int'($urandom_range(0, 15)) - 8);
            default: return gcsm_pkg::t_sample'($urandom);
        endcase
    endfunction

    // one sample transaction, then an optional gap
    task automatic send_sample(gcsm_pkg::t_sample s, logic eos);
        int unsigned gap;
        in_ch.valid         <= 1'b1;
        in_ch.sample        <= s;
        in_ch.end_of_series <= eos;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        gap = gap_len();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for every expected result, then let the block drain
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers on consecutive edges
    task automatic set_config(logic [gcsm_pkg::CFG_W-1:0] win,
                              logic [gcsm_pkg::CFG_W-1:0] grp);
        cfg_we   <= 1'b1;
        cfg_idx  <= gcsm_pkg::CFG_WINDOW_LEN;
        cfg_data <= win;
        @(posedge i_clk);
        cfg_idx  <= gcsm_pkg::CFG_WIN_PER_GRP;
        cfg_data <= grp;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // result back-pressure
    initial begin
        int unsigned stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (calm) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = gap_len();
                if (stall != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin
        int unsigned sent;
        int unsigned burst;
        logic [gcsm_pkg::CFG_W-1:0] win;
        logic [gcsm_pkg::CFG_W-1:0] grp;
        calm                = 1'b0;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= gcsm_pkg::CFG_WINDOW_LEN;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.sample       <= '0;
        in_ch.end_of_series <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, group of four with the sample extremes
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(0, 1'b0);
        // partial group at least one window long, with a tie
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(-7, 1'b1);
        // partial group shorter than the window
        send_sample(-3, 1'b1);
        quiesce();

        // zero window and zero k, so every sample is a group
        set_config(7'd0, 7'd0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        quiesce();

        // both registers saturated, short flush
        set_config(7'd127, 7'd127);
        send_sample(9, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(4, 1'b1);
        quiesce();

        // group length shrunk mid-group, the overlong group goes out at once
        set_config(7'd8, 7'd8);
        repeat (6) send_sample(draw_sample(), 1'b0);
        quiesce();
        set_config(7'd2, 7'd2);
        send_sample(draw_sample(), 1'b0);
        // end of series on the sample that fills the group
        repeat (3) send_sample(draw_sample(), 1'b0);
        send_sample(draw_sample(), 1'b1);
        quiesce();

        // random phases, each with its own settings
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin win = 7'd0;                     grp = 7'($urandom_range(0, 127)); end
                1: begin win = 7'($urandom_range(64, 127)); grp = 7'($urandom_range(0, 3)); end
                2: begin win = 7'd1;                     grp = 7'($urandom_range(0, 127)); end
                3: begin win = 7'($urandom_range(1, 16));  grp = 7'($urandom_range(65, 127)); end
                4: begin win = 7'd64;                    grp = 7'd1; end
                default: begin
                    win = 7'($urandom_range(1, 8));
                    grp = 7'($urandom_range(1, 8));
                end
            endcase
            set_config(win, grp);
            calm  = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(6, 40);
            repeat (burst) begin
                send_sample(draw_sample(), logic'($urandom_range(0, 15) == 0));
                sent++;
            end
            quiesce();
        end

        if (failures == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
